>>> hw/rtl/pbrl_pkg.sv
// Shared types, register codes and reset values for the posting back-off rate limiter.
`timescale 1ns / 1ps
`default_nettype none

package pbrl_pkg;

    // Default number of client records.
    localparam int unsigned CLIENTS_DEFAULT = 256;

    // Field widths.
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SLEEP_W  = 16;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned FACTOR_W = 8;
    localparam int unsigned WINDOW_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_WINDOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_COUNT  = 2'd3;

    // Register reset values.
    localparam logic [FACTOR_W-1:0] BACKOFF_FACTOR_RESET = 8'd1;
    localparam logic [WINDOW_W-1:0] FAST_WINDOW_RESET    = 16'd0;
    localparam logic [WINDOW_W-1:0] SLOW_WINDOW_RESET    = 16'd0;
    localparam logic [COUNT_W-1:0]  TRIGGER_COUNT_RESET  = 16'd0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One client record as it sits in the record memory.
    typedef struct packed {
        logic               valid;
        logic [TIME_W-1:0]  last_time;
        logic [SLEEP_W-1:0] last_sleep;
        logic [COUNT_W-1:0] count;
    } record_t;

    // Configuration register set.
    typedef struct packed {
        logic [FACTOR_W-1:0] backoff_factor;
        logic [WINDOW_W-1:0] fast_window;
        logic [WINDOW_W-1:0] slow_window;
        logic [COUNT_W-1:0]  trigger_count;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/posting_backoff_rate_limiter.sv
// Top level of the posting back-off rate limiter: handshakes, registers and sequencing.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one post request (client index and current time in seconds); each
// output beat returns the sleep the poster must take and the client's updated count of
// consecutive posts. Per-client records live in one synchronous memory of CLIENTS
// entries. In the cycle a request is accepted its record is read into a register, and
// in the busy state that follows the record is updated, written back and the result is
// loaded into the output register. Because the write-back lands before the following
// request's read, back-to-back requests to the same client need no forwarding. The
// output register decouples the two sides: a new request is accepted while a result
// still waits, and the update cycle holds only if the output register is still full.
// After reset a clearing pass over all CLIENTS entries marks every record
// invalid; no request is accepted during that pass, while configuration writes are
// taken at all times. A client index at or above CLIENTS wraps modulo CLIENTS.
// Configuration should only be written while no request is in flight.

module posting_backoff_rate_limiter #(
    parameter int unsigned CLIENTS = pbrl_pkg::CLIENTS_DEFAULT,
    localparam int unsigned ADDR_W = $clog2(CLIENTS)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [7:0] client_index, [39:8] now_time
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] sleep_time, [31:16] post_count
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [pbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pbrl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned INDEX_RANGE = 2 ** pbrl_pkg::INDEX_W;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t state_reg;

    logic [pbrl_pkg::INDEX_W-1:0] in_client_index;
    logic [pbrl_pkg::TIME_W-1:0]  in_now_time;
    logic                         in_beat;

    logic [ADDR_W-1:0]            slot_reg;
    logic [pbrl_pkg::TIME_W-1:0]  now_reg;
    logic                         out_valid_reg;
    logic [pbrl_pkg::SLEEP_W-1:0] sleep_reg;
    logic [pbrl_pkg::COUNT_W-1:0] count_reg;

    pbrl_pkg::cfg_t               cfg_reg;

    logic [ADDR_W-1:0]            slot_lut [INDEX_RANGE];
    logic [ADDR_W-1:0]            in_slot;

    pbrl_pkg::record_t            rd_rec;
    pbrl_pkg::record_t            new_rec;
    logic                         store_ready;
    logic                         wb_en;

    assign in_client_index = s_axis_tdata[7:0];
    assign in_now_time     = s_axis_tdata[39:8];

    // Index-to-slot table, built at elaboration so that any CLIENTS wraps correctly.
    for (genvar g = 0; g < INDEX_RANGE; g++)
    begin : g_slot
        assign slot_lut[g] = ADDR_W'(g % CLIENTS);
    end

    assign in_slot = slot_lut[in_client_index];

    assign s_axis_tready = (state_reg == ST_IDLE) && store_ready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // The update commits only when the output register can take the result.
    assign wb_en = (state_reg == ST_BUSY) && (!out_valid_reg || m_axis_tready);

    pbrl_store #(
        .CLIENTS (CLIENTS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (in_beat),
        .rd_addr     (in_slot),
        .rd_data     (rd_rec),
        .wr_en       (wb_en),
        .wr_addr     (slot_reg),
        .wr_data     (new_rec),
        .store_ready (store_ready)
    );

    pbrl_update u_update (
        .rec      (rd_rec),
        .now_time (now_reg),
        .cfg      (cfg_reg),
        .new_rec  (new_rec)
    );

    // Request sequencing and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= ST_BUSY;
                    end
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_BUSY:
                begin
                    if (wb_en)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            slot_reg <= in_slot;
            now_reg  <= in_now_time;
        end
        if (wb_en)
        begin
            sleep_reg <= new_rec.last_sleep;
            count_reg <= new_rec.count;
        end
    end

    // Configuration registers; the channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.backoff_factor <= pbrl_pkg::BACKOFF_FACTOR_RESET;
            cfg_reg.fast_window    <= pbrl_pkg::FAST_WINDOW_RESET;
            cfg_reg.slow_window    <= pbrl_pkg::SLOW_WINDOW_RESET;
            cfg_reg.trigger_count  <= pbrl_pkg::TRIGGER_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pbrl_pkg::REG_BACKOFF_FACTOR:
                    cfg_reg.backoff_factor <= cfg_data[pbrl_pkg::FACTOR_W-1:0];
                pbrl_pkg::REG_FAST_WINDOW:
                    cfg_reg.fast_window <= cfg_data;
                pbrl_pkg::REG_SLOW_WINDOW:
                    cfg_reg.slow_window <= cfg_data;
                pbrl_pkg::REG_TRIGGER_COUNT:
                    cfg_reg.trigger_count <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {count_reg, sleep_reg};

    // A request is never taken while the clearing pass still owns the memory.
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_beat |-> store_ready
    ) else $error("request accepted during clearing pass");

    // An accepted request is always followed by its update cycle.
    a_accept_then_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_BUSY)
    ) else $error("accepted request did not enter update cycle");

    // A committed update always presents a result in the next cycle.
    a_commit_then_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        wb_en |=> m_axis_tvalid
    ) else $error("write-back without a result");

    // The post count of a delivered result is never zero.
    a_count_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (count_reg != '0)
    ) else $error("result with zero post count");

endmodule

`default_nettype wire

>>> hw/rtl/pbrl_store.sv
// Client record memory with its clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module pbrl_store #(
    parameter int unsigned CLIENTS = pbrl_pkg::CLIENTS_DEFAULT,
    localparam int unsigned ADDR_W = $clog2(CLIENTS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output pbrl_pkg::record_t     rd_data,
    input  wire logic             wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire pbrl_pkg::record_t wr_data,
    output logic                  store_ready
);

    pbrl_pkg::record_t mem [CLIENTS];
    pbrl_pkg::record_t rd_data_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_done_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    pbrl_pkg::record_t mem_wdata;

    // The clearing pass owns the write port until every record is invalid.
    always_comb
    begin
        if (!clr_done_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            if (clr_addr_reg == ADDR_W'(CLIENTS - 1))
            begin
                clr_done_reg <= 1'b1;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data     = rd_data_reg;
    assign store_ready = clr_done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pbrl_update.sv
// Next-record computation: sleep and post count from a stored record and the registers.
`timescale 1ns / 1ps
`default_nettype none

module pbrl_update (
    input  wire pbrl_pkg::record_t                 rec,
    input  wire logic [pbrl_pkg::TIME_W-1:0]       now_time,
    input  wire pbrl_pkg::cfg_t                    cfg,
    output pbrl_pkg::record_t                      new_rec
);

    localparam int unsigned PROD_W = pbrl_pkg::SLEEP_W + pbrl_pkg::FACTOR_W;
    localparam int unsigned GROW_W = PROD_W + 1;

    logic [pbrl_pkg::SLEEP_W-1:0] held;
    logic [pbrl_pkg::TIME_W-1:0]  elapsed;
    logic                         fast_hit;
    logic                         slow_hit;
    logic                         triggered;
    logic [PROD_W-1:0]            prod;
    logic [GROW_W-1:0]            grow;
    logic [GROW_W-1:0]            sleep_raw;
    logic [pbrl_pkg::COUNT_W-1:0] count_base;
    logic [pbrl_pkg::COUNT_W-1:0] count_new;
    logic [pbrl_pkg::SLEEP_W-1:0] sleep_new;

    always_comb
    begin
        held = (rec.last_sleep > cfg.fast_window) ? cfg.fast_window : rec.last_sleep;
        // A clock that runs backwards counts as no time gone by.
        elapsed   = (now_time >= rec.last_time) ? (now_time - rec.last_time) : '0;
        fast_hit  = elapsed < pbrl_pkg::TIME_W'(cfg.fast_window);
        slow_hit  = elapsed < pbrl_pkg::TIME_W'(cfg.slow_window);
        triggered = rec.count >= cfg.trigger_count;
        prod      = PROD_W'(held) * PROD_W'(cfg.backoff_factor);
        grow      = GROW_W'(prod) + GROW_W'(1);

        sleep_raw  = '0;
        count_base = rec.count;
        if (!rec.valid)
        begin
            count_base = '0;
        end
        else if (fast_hit)
        begin
            if (triggered)
            begin
                sleep_raw = grow;
            end
        end
        else if (slow_hit)
        begin
            if (triggered)
            begin
                sleep_raw = GROW_W'(held);
            end
        end
        else
        begin
            count_base = '0;
        end

        count_new = (count_base == pbrl_pkg::COUNT_MAX) ? count_base : count_base + 1'b1;
        sleep_new = (sleep_raw > GROW_W'(cfg.fast_window)) ? cfg.fast_window
                                                            : sleep_raw[pbrl_pkg::SLEEP_W-1:0];

        new_rec.valid      = 1'b1;
        new_rec.last_time  = now_time;
        new_rec.last_sleep = sleep_new;
        new_rec.count      = count_new;
    end

endmodule

`default_nettype wire
